### rtl/btwd_pkg.sv
`timescale 1ns / 1ps
// Package for the bearing to world direction unit: widths, fixed-point constants,
// mode and register codes, the pipeline tag type and small arithmetic helpers.
// Depends on nothing.
package btwd_pkg;

    // Field and datapath widths.
    localparam int FRAC_BITS = 14;
    localparam int ANGLE_W   = 16;
    localparam int AXIS_W    = 16;
    localparam int OUT_W     = 18;
    localparam int ROW_W     = 19;
    localparam int ADJ_W     = 37;
    localparam int DET_W     = 56;
    localparam int DMAG_W    = DET_W - 1;
    localparam int PTR_W     = 16;
    localparam int NUM_W     = 55;
    localparam int NMAG_W    = NUM_W - 1;
    localparam int DVS_W     = DMAG_W + 4;
    localparam int REM_W     = DVS_W + 1;
    localparam int QUO_W     = OUT_W + 1;

    // Divider layout: quotient bits, bits per stage and stage count.
    localparam int DIV_STEPS  = QUO_W;
    localparam int DIV_PER_ST = 2;
    localparam int DIV_ST     = (DIV_STEPS + DIV_PER_ST - 1) / DIV_PER_ST;

    // Pipeline stage numbering of the item path.
    localparam int ST_DIV0 = 15;
    localparam int ST_LAST = ST_DIV0 + DIV_ST;

    // Configuration settle time after any register write.
    localparam logic [2:0] SETUP_LEN = 3'd7;

    // Angle constants: a quarter turn, octant bound and Q30 scaling.
    localparam logic [ANGLE_W-1:0] QUARTER_TURN = ANGLE_W'(1 << (ANGLE_W - 2));
    localparam logic [13:0]        OCT_BOUND    = 14'd8192;
    localparam logic [14:0]        QUAD_SPAN    = 15'd16384;
    localparam logic [30:0]        ONE_Q30      = 31'h4000_0000;
    localparam logic [31:0]        HALF_PI_Q31  = 32'd3373259426;
    localparam int                 ARG_SHIFT    = 15;
    localparam int                 PTR_XY_SHIFT = 60 - FRAC_BITS;
    localparam int                 PTR_Z_SHIFT  = 30 - FRAC_BITS;

    // Reciprocal multipliers for exact floor division of values below 2^30.
    localparam int          SH_42 = 36;
    localparam int          SH_20 = 35;
    localparam int          SH_6  = 33;
    localparam int          SH_56 = 36;
    localparam int          SH_30 = 35;
    localparam int          SH_12 = 34;
    localparam logic [31:0] M_42  = 32'(((64'd1 << SH_42) + 64'd41) / 64'd42);
    localparam logic [31:0] M_20  = 32'(((64'd1 << SH_20) + 64'd19) / 64'd20);
    localparam logic [31:0] M_6   = 32'(((64'd1 << SH_6) + 64'd5) / 64'd6);
    localparam logic [31:0] M_56  = 32'(((64'd1 << SH_56) + 64'd55) / 64'd56);
    localparam logic [31:0] M_30  = 32'(((64'd1 << SH_30) + 64'd29) / 64'd30);
    localparam logic [31:0] M_12  = 32'(((64'd1 << SH_12) + 64'd11) / 64'd12);

    // Output saturation limits.
    localparam logic [QUO_W-1:0] OUT_POS_MAX = QUO_W'((1 << (OUT_W - 1)) - 1);
    localparam logic [QUO_W-1:0] OUT_NEG_MAG = QUO_W'(1 << (OUT_W - 1));

    // Array shape codes.
    localparam logic [2:0] MODE_NONE   = 3'd0;
    localparam logic [2:0] MODE_POINT  = 3'd1;
    localparam logic [2:0] MODE_LINE   = 3'd2;
    localparam logic [2:0] MODE_PLANE  = 3'd3;
    localparam logic [2:0] MODE_VOLUME = 3'd4;

    // Configuration register indexes.
    localparam logic [3:0] REG_ARRAY_MODE    = 4'd0;
    localparam logic [3:0] REG_AXIS_COUNT    = 4'd1;
    localparam logic [3:0] REG_FIRST_AXIS_X  = 4'd2;
    localparam logic [3:0] REG_FIRST_AXIS_Y  = 4'd3;
    localparam logic [3:0] REG_FIRST_AXIS_Z  = 4'd4;
    localparam logic [3:0] REG_SECOND_AXIS_X = 4'd5;
    localparam logic [3:0] REG_SECOND_AXIS_Y = 4'd6;
    localparam logic [3:0] REG_SECOND_AXIS_Z = 4'd7;

    // Per-result control that travels down the pipeline with its valid bit.
    typedef struct packed {
        logic neg_y;
        logic neg_z;
        logic cone;
        logic last;
    } tag_t;

    // Octant folding per angle lane.
    typedef struct packed {
        logic [1:0] quad;
        logic       swap;
    } fold_t;

    // Signed shift right with rounding half away from zero.
    function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                   input int unsigned sh);
        logic [63:0] mag;
        logic        neg;
        neg = v[63];
        mag = neg ? 64'(-v) : 64'(v);
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    // Floor division by a constant through its reciprocal multiplier.
    function automatic logic [29:0] div_const(input logic [29:0] v,
                                              input logic [31:0] mul,
                                              input int unsigned sh);
        logic [63:0] prod;
        prod = 64'(v) * 64'(mul);
        return 30'(prod >> sh);
    endfunction

    // Q30 product, truncated.
    function automatic logic [29:0] mul_q30(input logic [29:0] a, input logic [30:0] b);
        logic [63:0] prod;
        prod = 64'(a) * 64'(b);
        return 30'(prod >> 30);
    endfunction

endpackage

### rtl/bearing_to_world_direction_unit.sv
`timescale 1ns / 1ps
// Bearing to world direction unit: sine/cosine pipeline, frame setup, adjugate
// product and pipelined divider. Depends on btwd_pkg.
//
//  Channel   Handshake                    Payload
//  --------  ---------------------------  ------------------------------------------
//  item in   start && !busy               azimuth, elevation, has_elevation
//  result    done (one cycle, no stall)   dir_x, dir_y, dir_z, is_cone, is_last
//  config    cfg_valid && cfg_ready       cfg_index, cfg_data
//
// done and the result are registered from the last stage of the item pipeline.
// Volume mode takes one item per cycle while busy is low; line and plane modes hold off the next
// item while the second result of a pair enters the pipeline in the cycle after the first.
// After reset and after every configuration write, busy stays high while the frame,
// its adjugate and determinant are rebuilt. cfg_ready is always high. Results cannot
// be stalled, so the pipeline never holds.
module bearing_to_world_direction_unit
    import btwd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [ANGLE_W-1:0] azimuth,
    input  logic signed [ANGLE_W-1:0] elevation,
    input  logic                     has_elevation,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [3:0]               cfg_index,
    input  logic [AXIS_W-1:0]        cfg_data,
    output logic                     done,
    output logic signed [OUT_W-1:0]  dir_x,
    output logic signed [OUT_W-1:0]  dir_y,
    output logic signed [OUT_W-1:0]  dir_z,
    output logic                     is_cone,
    output logic                     is_last
);

    localparam int NXT1 [3] = '{1, 2, 0};
    localparam int NXT2 [3] = '{2, 0, 1};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [2:0]               array_mode_reg;
    logic [1:0]               axis_count_reg;
    logic signed [AXIS_W-1:0] axis_a_reg [3];
    logic signed [AXIS_W-1:0] axis_b_reg [3];
    logic [2:0]               setup_cnt_reg;
    logic                     cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Register writes; any write restarts the frame setup.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            array_mode_reg <= MODE_NONE;
            axis_count_reg <= 2'd0;
            axis_a_reg[0]  <= AXIS_W'(1 << FRAC_BITS);
            axis_a_reg[1]  <= '0;
            axis_a_reg[2]  <= '0;
            axis_b_reg[0]  <= '0;
            axis_b_reg[1]  <= AXIS_W'(1 << FRAC_BITS);
            axis_b_reg[2]  <= '0;
            setup_cnt_reg  <= SETUP_LEN;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_ARRAY_MODE:    array_mode_reg <= cfg_data[2:0];
                    REG_AXIS_COUNT:    axis_count_reg <= cfg_data[1:0];
                    REG_FIRST_AXIS_X:  axis_a_reg[0]  <= cfg_data;
                    REG_FIRST_AXIS_Y:  axis_a_reg[1]  <= cfg_data;
                    REG_FIRST_AXIS_Z:  axis_a_reg[2]  <= cfg_data;
                    REG_SECOND_AXIS_X: axis_b_reg[0]  <= cfg_data;
                    REG_SECOND_AXIS_Y: axis_b_reg[1]  <= cfg_data;
                    REG_SECOND_AXIS_Z: axis_b_reg[2]  <= cfg_data;
                    default:           ;
                endcase
                setup_cnt_reg <= SETUP_LEN;
            end
            else if (setup_cnt_reg != 3'd0)
            begin
                setup_cnt_reg <= setup_cnt_reg - 3'd1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Frame setup chain, rebuilt after each write while setup_cnt_reg counts down
    // ------------------------------------------------------------------
    logic signed [ROW_W-1:0]   f1_r0_reg [3];
    logic signed [ROW_W-1:0]   f1_r1_reg [3];
    logic                      f1_fixed_reg;
    logic signed [ROW_W-1:0]   f1_r1_next [3];
    logic signed [2*ROW_W-1:0] f2_ca_reg [3];
    logic signed [2*ROW_W-1:0] f2_cb_reg [3];
    logic signed [ROW_W-1:0]   f2_r0_reg [3];
    logic signed [ROW_W-1:0]   f2_r1_reg [3];
    logic                      f2_fixed_reg;
    logic signed [ROW_W-1:0]   m_reg [3][3];
    logic signed [2*ROW_W-1:0] f4_pa_reg [3][3];
    logic signed [2*ROW_W-1:0] f4_pb_reg [3][3];
    logic signed [ADJ_W-1:0]   adj_reg [3][3];
    logic signed [ADJ_W+ROW_W-1:0] f6_dp_reg [3];
    logic                      det_neg_reg;
    logic                      det_nz_reg;
    logic [DMAG_W-1:0]         dmag_reg;
    logic signed [DET_W-1:0]   det_sum;
    logic [DVS_W-1:0]          dvs;

    // Second row: supplied axis, horizontal perpendicular, or the x axis.
    always_comb
    begin
        if (axis_count_reg == 2'd1)
        begin
            if (axis_a_reg[0] == '0 && axis_a_reg[1] == '0)
            begin
                f1_r1_next[0] = ROW_W'(1 << FRAC_BITS);
                f1_r1_next[1] = '0;
            end
            else
            begin
                f1_r1_next[0] = -ROW_W'(axis_a_reg[1]);
                f1_r1_next[1] = ROW_W'(axis_a_reg[0]);
            end
            f1_r1_next[2] = '0;
        end
        else
        begin
            for (int k = 0; k < 3; k++)
            begin
                f1_r1_next[k] = ROW_W'(axis_b_reg[k]);
            end
        end
    end

    assign det_sum = DET_W'(f6_dp_reg[0]) + DET_W'(f6_dp_reg[1]) + DET_W'(f6_dp_reg[2]);
    assign dvs     = DVS_W'(dmag_reg) << 4;

    always_ff @(posedge clk)
    begin
        // Rows from the axes.
        for (int k = 0; k < 3; k++)
        begin
            f1_r0_reg[k] <= ROW_W'(axis_a_reg[k]);
            f1_r1_reg[k] <= f1_r1_next[k];
        end
        f1_fixed_reg <= (axis_count_reg == 2'd0);
        // Cross product terms.
        for (int k = 0; k < 3; k++)
        begin
            f2_ca_reg[k] <= f1_r0_reg[NXT1[k]] * f1_r1_reg[NXT2[k]];
            f2_cb_reg[k] <= f1_r0_reg[NXT2[k]] * f1_r1_reg[NXT1[k]];
            f2_r0_reg[k] <= f1_r0_reg[k];
            f2_r1_reg[k] <= f1_r1_reg[k];
        end
        f2_fixed_reg <= f1_fixed_reg;
        // Frame matrix, or the fixed frame when no axis is given.
        for (int k = 0; k < 3; k++)
        begin
            if (f2_fixed_reg)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    m_reg[k][j] <= ((k == 2 && j == 2) || (k + j == 1))
                                   ? ROW_W'(1 << FRAC_BITS) : '0;
                end
            end
            else
            begin
                m_reg[0][k] <= f2_r0_reg[k];
                m_reg[1][k] <= f2_r1_reg[k];
                m_reg[2][k] <= ROW_W'(rnd_shr(64'(f2_ca_reg[k]) - 64'(f2_cb_reg[k]),
                                              FRAC_BITS));
            end
        end
        // Adjugate cofactor products and differences.
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                f4_pa_reg[i][j] <= m_reg[NXT1[j]][NXT1[i]] * m_reg[NXT2[j]][NXT2[i]];
                f4_pb_reg[i][j] <= m_reg[NXT1[j]][NXT2[i]] * m_reg[NXT2[j]][NXT1[i]];
                adj_reg[i][j]   <= ADJ_W'(f4_pa_reg[i][j] - f4_pb_reg[i][j]);
            end
        end
        // Determinant along the first row.
        for (int j = 0; j < 3; j++)
        begin
            f6_dp_reg[j] <= m_reg[0][j] * adj_reg[j][0];
        end
        det_neg_reg <= det_sum[DET_W-1];
        det_nz_reg  <= (det_sum != '0);
        dmag_reg    <= DMAG_W'(det_sum[DET_W-1] ? -det_sum : det_sum);
    end

    // ------------------------------------------------------------------
    // Item entry: first slot on accept, second slot of a pair in the next cycle, not later
    // ------------------------------------------------------------------
    logic                     accept;
    logic                     mode_ok;
    logic                     emit;
    logic                     pair;
    logic                     pend_reg;
    logic [ST_LAST:0]         vld_reg;
    tag_t                     tag_reg [ST_LAST+1];
    tag_t                     tag0_next;
    logic [ANGLE_W-1:0]       s0_az_reg;
    logic [ANGLE_W-1:0]       s0_el_reg;
    logic                     s0_has_reg;

    assign busy    = (setup_cnt_reg != 3'd0) || pend_reg;
    assign accept  = start && !busy;
    assign mode_ok = (array_mode_reg == MODE_LINE) || (array_mode_reg == MODE_PLANE) ||
                     (array_mode_reg == MODE_VOLUME);
    assign emit    = mode_ok && det_nz_reg;
    assign pair    = (array_mode_reg == MODE_LINE) || (array_mode_reg == MODE_PLANE);

    // Second slot mirrors y in line mode, z in plane mode with a real frame.
    always_comb
    begin
        tag0_next.cone = (array_mode_reg == MODE_LINE);
        if (pend_reg)
        begin
            tag0_next.neg_y = (array_mode_reg == MODE_LINE);
            tag0_next.neg_z = (array_mode_reg == MODE_PLANE) && (axis_count_reg != 2'd0);
            tag0_next.last  = 1'b1;
        end
        else
        begin
            tag0_next.neg_y = 1'b0;
            tag0_next.neg_z = 1'b0;
            tag0_next.last  = !pair;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            vld_reg  <= '0;
        end
        else
        begin
            pend_reg <= accept && emit && pair;
            vld_reg  <= {vld_reg[ST_LAST-1:0], (accept && emit) || pend_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_az_reg  <= azimuth;
            s0_el_reg  <= elevation;
            s0_has_reg <= has_elevation;
        end
        tag_reg[0] <= tag0_next;
        for (int k = 1; k <= ST_LAST; k++)
        begin
            tag_reg[k] <= tag_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Sine/cosine pipeline, lane 0 heading and lane 1 slant
    // ------------------------------------------------------------------
    logic [ANGLE_W-1:0] ang [2];
    logic [29:0]        s1_x_next [2];
    fold_t              s1_f_next [2];
    logic [29:0]        s1_x_reg [2], s2_x_reg [2], s3_x_reg [2], s4_x_reg [2];
    logic [29:0]        s5_x_reg [2], s6_x_reg [2], s7_x_reg [2];
    logic [29:0]        s2_x2_reg [2], s3_x2_reg [2], s4_x2_reg [2], s5_x2_reg [2];
    logic [29:0]        s6_x2_reg [2], s7_x2_reg [2];
    fold_t              s1_f_reg [2], s2_f_reg [2], s3_f_reg [2], s4_f_reg [2];
    fold_t              s5_f_reg [2], s6_f_reg [2], s7_f_reg [2], s8_f_reg [2];
    logic [30:0]        s3_ts_reg [2], s3_tc_reg [2], s5_ts_reg [2], s5_tc_reg [2];
    logic [30:0]        s7_ts_reg [2], s7_tc_reg [2];
    logic [29:0]        s4_ms_reg [2], s4_mc_reg [2], s6_ms_reg [2], s6_mc_reg [2];
    logic [29:0]        s8_so_reg [2], s8_mc_reg [2];
    logic signed [31:0] s9_sin_reg [2];
    logic signed [31:0] s9_cos_reg [2];
    logic signed [31:0] sv [2];
    logic signed [31:0] cv [2];
    logic [30:0]        co [2];

    assign ang[0] = QUARTER_TURN - s0_az_reg;
    assign ang[1] = s0_has_reg ? s0_el_reg : '0;

    // Fold each angle into the first octant and scale to radians.
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            s1_f_next[l].quad = ang[l][ANGLE_W-1:ANGLE_W-2];
            s1_f_next[l].swap = ang[l][13:0] > OCT_BOUND;
            s1_x_next[l] = 30'((46'(s1_f_next[l].swap ? 14'(QUAD_SPAN - 15'(ang[l][13:0]))
                                                     : ang[l][13:0])
                                * 46'(HALF_PI_Q31)) >> ARG_SHIFT);
        end
    end

    // Octant unfold of the series results.
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            co[l] = ONE_Q30 - 31'(s8_mc_reg[l] >> 1);
            sv[l] = s8_f_reg[l].swap ? 32'(co[l]) : 32'(s8_so_reg[l]);
            cv[l] = s8_f_reg[l].swap ? 32'(s8_so_reg[l]) : 32'(co[l]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 2; l++)
        begin
            // Argument and its square.
            s1_x_reg[l]  <= s1_x_next[l];
            s1_f_reg[l]  <= s1_f_next[l];
            s2_x_reg[l]  <= s1_x_reg[l];
            s2_x2_reg[l] <= mul_q30(s1_x_reg[l], 31'(s1_x_reg[l]));
            s2_f_reg[l]  <= s1_f_reg[l];
            // First Horner term.
            s3_x_reg[l]  <= s2_x_reg[l];
            s3_x2_reg[l] <= s2_x2_reg[l];
            s3_ts_reg[l] <= ONE_Q30 - 31'(div_const(s2_x2_reg[l], M_42, SH_42));
            s3_tc_reg[l] <= ONE_Q30 - 31'(div_const(s2_x2_reg[l], M_56, SH_56));
            s3_f_reg[l]  <= s2_f_reg[l];
            s4_x_reg[l]  <= s3_x_reg[l];
            s4_x2_reg[l] <= s3_x2_reg[l];
            s4_ms_reg[l] <= mul_q30(s3_x2_reg[l], s3_ts_reg[l]);
            s4_mc_reg[l] <= mul_q30(s3_x2_reg[l], s3_tc_reg[l]);
            s4_f_reg[l]  <= s3_f_reg[l];
            // Second Horner term.
            s5_x_reg[l]  <= s4_x_reg[l];
            s5_x2_reg[l] <= s4_x2_reg[l];
            s5_ts_reg[l] <= ONE_Q30 - 31'(div_const(s4_ms_reg[l], M_20, SH_20));
            s5_tc_reg[l] <= ONE_Q30 - 31'(div_const(s4_mc_reg[l], M_30, SH_30));
            s5_f_reg[l]  <= s4_f_reg[l];
            s6_x_reg[l]  <= s5_x_reg[l];
            s6_x2_reg[l] <= s5_x2_reg[l];
            s6_ms_reg[l] <= mul_q30(s5_x2_reg[l], s5_ts_reg[l]);
            s6_mc_reg[l] <= mul_q30(s5_x2_reg[l], s5_tc_reg[l]);
            s6_f_reg[l]  <= s5_f_reg[l];
            // Third Horner term.
            s7_x_reg[l]  <= s6_x_reg[l];
            s7_x2_reg[l] <= s6_x2_reg[l];
            s7_ts_reg[l] <= ONE_Q30 - 31'(div_const(s6_ms_reg[l], M_6, SH_6));
            s7_tc_reg[l] <= ONE_Q30 - 31'(div_const(s6_mc_reg[l], M_12, SH_12));
            s7_f_reg[l]  <= s6_f_reg[l];
            s8_so_reg[l] <= mul_q30(s7_x_reg[l], s7_ts_reg[l]);
            s8_mc_reg[l] <= mul_q30(s7_x2_reg[l], s7_tc_reg[l]);
            s8_f_reg[l]  <= s7_f_reg[l];
            // Signed sine and cosine of the full angle.
            unique case (s8_f_reg[l].quad)
                2'd0:
                begin
                    s9_sin_reg[l] <= sv[l];
                    s9_cos_reg[l] <= cv[l];
                end
                2'd1:
                begin
                    s9_sin_reg[l] <= cv[l];
                    s9_cos_reg[l] <= -sv[l];
                end
                2'd2:
                begin
                    s9_sin_reg[l] <= -sv[l];
                    s9_cos_reg[l] <= -cv[l];
                end
                default:
                begin
                    s9_sin_reg[l] <= -cv[l];
                    s9_cos_reg[l] <= sv[l];
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pointer and adjugate product
    // ------------------------------------------------------------------
    logic signed [63:0]            s10_px_reg;
    logic signed [63:0]            s10_py_reg;
    logic signed [31:0]            s10_se_reg;
    logic signed [PTR_W-1:0]       s11_p_reg [3];
    logic signed [PTR_W-1:0]       py;
    logic signed [PTR_W-1:0]       pz;
    logic signed [ADJ_W+PTR_W-1:0] s12_pr_reg [3][3];
    logic signed [NUM_W-1:0]       s13_num_reg [3];
    logic                          s14_neg_reg [3];
    logic [NMAG_W-1:0]             s14_nmag_reg [3];

    assign py = PTR_W'(rnd_shr(s10_py_reg, PTR_XY_SHIFT));
    assign pz = PTR_W'(rnd_shr(64'(s10_se_reg), PTR_Z_SHIFT));

    always_ff @(posedge clk)
    begin
        s10_px_reg   <= 64'(s9_cos_reg[1]) * 64'(s9_sin_reg[0]);
        s10_py_reg   <= 64'(s9_cos_reg[1]) * 64'(s9_cos_reg[0]);
        s10_se_reg   <= s9_sin_reg[1];
        // Rounded pointer, mirrored as the slot asks.
        s11_p_reg[0] <= PTR_W'(rnd_shr(s10_px_reg, PTR_XY_SHIFT));
        s11_p_reg[1] <= tag_reg[10].neg_y ? -py : py;
        s11_p_reg[2] <= tag_reg[10].neg_z ? -pz : pz;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                s12_pr_reg[i][j] <= (ADJ_W+PTR_W)'(adj_reg[i][j]) *
                                    (ADJ_W+PTR_W)'(s11_p_reg[j]);
            end
            s13_num_reg[i]  <= NUM_W'(s12_pr_reg[i][0]) + NUM_W'(s12_pr_reg[i][1]) +
                               NUM_W'(s12_pr_reg[i][2]);
            s14_neg_reg[i]  <= s13_num_reg[i][NUM_W-1] ^ det_neg_reg;
            s14_nmag_reg[i] <= NMAG_W'(s13_num_reg[i][NUM_W-1] ? -s13_num_reg[i]
                                                               : s13_num_reg[i]);
        end
    end

    // ------------------------------------------------------------------
    // Pipelined restoring divider: floor(nmag * 2^15 / dmag), two bits a stage, one in the last stage
    // ------------------------------------------------------------------
    logic [REM_W-1:0] dv_rem_reg [DIV_ST+1][3];
    logic [QUO_W-1:0] dv_quo_reg [DIV_ST+1][3];
    logic             dv_ovf_reg [DIV_ST+1][3];
    logic             dv_neg_reg [DIV_ST+1][3];
    logic [REM_W-1:0] dv_rem_next [DIV_ST+1][3];
    logic [QUO_W-1:0] dv_quo_next [DIV_ST+1][3];

    always_comb
    begin
        logic [REM_W-1:0] rem;
        logic [REM_W-1:0] trial;
        logic [QUO_W-1:0] quo;
        for (int i = 0; i < 3; i++)
        begin
            dv_rem_next[0][i] = '0;
            dv_quo_next[0][i] = '0;
        end
        for (int k = 1; k <= DIV_ST; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rem = dv_rem_reg[k-1][i];
                quo = dv_quo_reg[k-1][i];
                for (int st = 0; st < DIV_PER_ST; st++)
                begin
                    if ((k - 1) * DIV_PER_ST + st < DIV_STEPS)
                    begin
                        trial = rem << 1;
                        if (trial >= REM_W'(dvs))
                        begin
                            rem = trial - REM_W'(dvs);
                            quo = {quo[QUO_W-2:0], 1'b1};
                        end
                        else
                        begin
                            rem = trial;
                            quo = {quo[QUO_W-2:0], 1'b0};
                        end
                    end
                end
                dv_rem_next[k][i] = rem;
                dv_quo_next[k][i] = quo;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        // Overflow when the quotient would not fit; else seed the remainder.
        for (int i = 0; i < 3; i++)
        begin
            dv_ovf_reg[0][i] <= REM_W'(s14_nmag_reg[i]) >= REM_W'(dvs);
            dv_rem_reg[0][i] <= (REM_W'(s14_nmag_reg[i]) >= REM_W'(dvs)) ? '0
                                : REM_W'(s14_nmag_reg[i]);
            dv_quo_reg[0][i] <= dv_quo_next[0][i];
            dv_neg_reg[0][i] <= s14_neg_reg[i];
        end
        for (int k = 1; k <= DIV_ST; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dv_rem_reg[k][i] <= dv_rem_next[k][i];
                dv_quo_reg[k][i] <= dv_quo_next[k][i];
                dv_ovf_reg[k][i] <= dv_ovf_reg[k-1][i];
                dv_neg_reg[k][i] <= dv_neg_reg[k-1][i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Rounding, saturation and result register
    // ------------------------------------------------------------------
    logic [QUO_W-1:0]        qr [3];
    logic signed [OUT_W-1:0] res [3];
    logic                    done_reg;
    logic signed [OUT_W-1:0] dir_reg [3];
    logic                    is_cone_reg;
    logic                    is_last_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qr[i] = QUO_W'(({1'b0, dv_quo_reg[DIV_ST][i]} + (QUO_W+1)'(1)) >> 1);
            if (!dv_neg_reg[DIV_ST][i])
            begin
                res[i] = (dv_ovf_reg[DIV_ST][i] || qr[i] > OUT_POS_MAX)
                         ? OUT_W'(OUT_POS_MAX) : OUT_W'(qr[i]);
            end
            else
            begin
                res[i] = (dv_ovf_reg[DIV_ST][i] || qr[i] > OUT_NEG_MAG)
                         ? -OUT_W'(OUT_NEG_MAG) : -OUT_W'(qr[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld_reg[ST_LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            dir_reg[i] <= res[i];
        end
        is_cone_reg <= tag_reg[ST_LAST].cone;
        is_last_reg <= tag_reg[ST_LAST].last;
    end

    assign done    = done_reg;
    assign dir_x   = dir_reg[0];
    assign dir_y   = dir_reg[1];
    assign dir_z   = dir_reg[2];
    assign is_cone = is_cone_reg;
    assign is_last = is_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // The second slot of a pair only follows an accepted transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(start && !busy))
    else $error("second slot without an accepted transaction");

    // The first result of a pair is followed at once by the last one.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && !is_last |=> done && is_last)
    else $error("result pair broken");

    // A register write holds off new items while the frame is rebuilt.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |=> busy)
    else $error("item accepted during frame setup");

endmodule
